// ----- rtl/core/ils_pkg.sv -----
`timescale 1ns / 1ps

package ils_pkg;

    // Fixed field widths of the request and response transfers.
    localparam int OP_W     = 4;
    localparam int POS_W    = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default list capacity.
    localparam int CAPACITY_DEF = 16;

    // Request codes.
    localparam logic [OP_W-1:0] OP_APPEND    = 4'd0;
    localparam logic [OP_W-1:0] OP_PREPEND   = 4'd1;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 4'd3;
    localparam logic [OP_W-1:0] OP_READ      = 4'd4;
    localparam logic [OP_W-1:0] OP_WRITE     = 4'd5;
    localparam logic [OP_W-1:0] OP_INSERT    = 4'd6;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd7;
    localparam logic [OP_W-1:0] OP_REVERSE   = 4'd8;

    // Response status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Commands broadcast to every cell of the chain.
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD   = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_WRITE  = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_INSERT = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_REMOVE = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_MIRROR = 3'd4;
    localparam logic [CELL_OP_W-1:0] CELL_SHIFT  = 3'd5;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        data_t            data_in;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        data_t               read_data;
        logic [COUNT_W-1:0]  count;
        data_t               first_data;
        data_t               last_data;
    } rsp_t;

endpackage

// ----- rtl/core/indexed_list_store.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a row of CAPACITY cells,
// entry 0 at the head. A request is taken at a rising edge where start is high
// and busy is low; its single response is on rsp for exactly one cycle, marked
// by done, in the cycle after the request for every operation except a reverse
// of a list with at least two but fewer than CAPACITY entries. Such a reverse
// mirrors the whole row and then slides the entries down towards the head one
// cell per cycle while busy is high, and done is high in the first cycle that
// busy is low again. The receiver cannot hold a response off: it must take it
// in the cycle that done is high.
// count, first_data and last_data show the list after the request; read_data
// is zero unless a read succeeded. Refused requests leave the list unchanged.
module indexed_list_store #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ils_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output ils_pkg::rsp_t rsp
);

    import ils_pkg::*;

    // Widths derived from the capacity: a cell index, a fill level that can
    // reach the capacity itself, and a width wide enough to compare the
    // request position with the fill level.
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(CAPACITY);

    // Controller states.
    localparam logic S_IDLE  = 1'b0;
    localparam logic S_SHIFT = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [FILL_W-1:0]   shift_cnt_reg;
    logic [FILL_W-1:0]   shift_cnt_next;
    logic                done_reg;
    logic                done_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    data_t               read_data_reg;
    data_t               read_data_next;

    logic [CELL_OP_W-1:0] cell_kind;
    logic [IDX_W-1:0]     cell_at;
    data_t                cell_val [CAPACITY];

    logic              accept;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  fill_ext;
    logic [IDX_W-1:0]  pos_idx;
    logic [IDX_W-1:0]  fill_idx;

    assign accept   = start && (state_reg == S_IDLE);
    assign full     = (fill_reg == FILL_MAX);
    assign empty    = (fill_reg == '0);
    assign pos_ext  = CMP_W'(req.position);
    assign fill_ext = CMP_W'(fill_reg);
    // Only used once the position is known to lie inside the row.
    assign pos_idx  = IDX_W'(pos_ext);
    assign fill_idx = IDX_W'(fill_reg);

    // Request decode. Prepend and append are inserts at either end, and
    // delete first is a removal at the head; delete last only drops the count.
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        shift_cnt_next = shift_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        read_data_next = read_data_reg;
        cell_kind      = CELL_HOLD;
        cell_at        = '0;

        if (state_reg == S_SHIFT)
        begin
            // Slide the mirrored entries down towards the head.
            cell_kind      = CELL_SHIFT;
            shift_cnt_next = shift_cnt_reg - 1'b1;
            if (shift_cnt_reg == FILL_W'(1))
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
        end
        else if (accept)
        begin
            status_next    = ST_DONE;
            read_data_next = '0;
            done_next      = 1'b1;
            unique case (req.op)
                OP_APPEND:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cell_kind = CELL_INSERT;
                        cell_at   = fill_idx;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_PREPEND:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cell_kind = CELL_INSERT;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_DEL_LAST:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                        fill_next = fill_reg - 1'b1;
                end
                OP_DEL_FIRST:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        cell_kind = CELL_REMOVE;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= fill_ext)
                        status_next = ST_RANGE;
                    else
                        read_data_next = cell_val[pos_idx];
                end
                OP_WRITE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= fill_ext)
                        status_next = ST_RANGE;
                    else
                    begin
                        cell_kind = CELL_WRITE;
                        cell_at   = pos_idx;
                    end
                end
                OP_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else if (pos_ext > fill_ext)
                        status_next = ST_RANGE;
                    else
                    begin
                        cell_kind = CELL_INSERT;
                        cell_at   = pos_idx;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_DEL_AT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_ext >= fill_ext)
                        status_next = ST_RANGE;
                    else
                    begin
                        cell_kind = CELL_REMOVE;
                        cell_at   = pos_idx;
                        fill_next = fill_reg - 1'b1;
                    end
                end
                OP_REVERSE:
                begin
                    // Mirroring the whole row leaves the list at the tail end;
                    // unless the row is full it then has to slide back down.
                    if (fill_reg > FILL_W'(1))
                    begin
                        cell_kind = CELL_MIRROR;
                        if (!full)
                        begin
                            state_next     = S_SHIFT;
                            shift_cnt_next = FILL_MAX - fill_reg;
                            done_next      = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            shift_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            shift_cnt_reg <= shift_cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        read_data_reg <= read_data_next;
    end

    // The row of cells. Each cell sees its two neighbours and its mirror
    // image; the end cells feed themselves where there is no neighbour.
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        data_t left_val;
        data_t right_val;

        if (k == 0)
        begin : g_head
            assign left_val = cell_val[k];
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_tail
            assign right_val = cell_val[k];
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[k+1];
        end

        ils_cell #(
            .IDX_W (IDX_W),
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .kind        (cell_kind),
            .at          (cell_at),
            .load_val    (req.data_in),
            .from_left   (left_val),
            .from_right  (right_val),
            .from_mirror (cell_val[CAPACITY-1-k]),
            .value       (cell_val[k])
        );
    end

    // Head and tail are read from the settled list in the response cycle.
    always_comb
    begin
        rsp.status     = status_reg;
        rsp.read_data  = read_data_reg;
        rsp.count      = COUNT_W'(fill_reg);
        rsp.first_data = '0;
        rsp.last_data  = '0;
        if (!empty)
        begin
            rsp.first_data = cell_val[0];
            rsp.last_data  = cell_val[IDX_W'(fill_reg - 1'b1)];
        end
    end

    assign busy = (state_reg == S_SHIFT);
    assign done = done_reg;

endmodule

// ----- rtl/core/ils_cell.sv -----
`timescale 1ns / 1ps

module ils_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                           clk,
    input  logic [ils_pkg::CELL_OP_W-1:0]  kind,
    input  logic [IDX_W-1:0]               at,
    input  ils_pkg::data_t                 load_val,
    input  ils_pkg::data_t                 from_left,
    input  ils_pkg::data_t                 from_right,
    input  ils_pkg::data_t                 from_mirror,
    output ils_pkg::data_t                 value
);

    import ils_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    data_t value_reg;
    data_t value_next;

    // Each cell compares the broadcast position with its own place in the row.
    always_comb
    begin
        unique case (kind)
            CELL_WRITE:
            begin
                value_next = (MY_IDX == at) ? load_val : value_reg;
            end
            CELL_INSERT:
            begin
                if (MY_IDX == at)
                    value_next = load_val;
                else if (MY_IDX > at)
                    value_next = from_left;
                else
                    value_next = value_reg;
            end
            CELL_REMOVE:
            begin
                value_next = (MY_IDX >= at) ? from_right : value_reg;
            end
            CELL_MIRROR:
            begin
                value_next = from_mirror;
            end
            CELL_SHIFT:
            begin
                value_next = from_right;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- rtl/core/ils_checker.sv -----
`timescale 1ns / 1ps

module ils_checker #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input ils_pkg::req_t req,
    input logic          busy,
    input logic          done,
    input ils_pkg::rsp_t rsp
);

    import ils_pkg::*;

    // An accepted request either answers in the next cycle or keeps the block busy.
    a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request neither answered nor busy");

    // No response is shown while the chain is still sliding.
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("response shown while busy");

    // The busy phase of a reverse ends with its response.
    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a response");

    // An empty list reports zero head and tail.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.count == '0) |-> (rsp.first_data == '0 && rsp.last_data == '0))
        else $error("empty list reports non-zero ends");

    // A full refusal only happens at capacity, and a refusal never returns data.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_DONE) |->
            (rsp.read_data == '0 &&
             (rsp.status != ST_FULL || rsp.count == COUNT_W'(CAPACITY))))
        else $error("refused request with inconsistent response");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the bounded ordered list store. Requests go in one
// per transfer on the start/busy handshake; every request returns exactly one
// response, marked by done. A shadow copy of the list, kept here, works out
// the response of each request at the moment its transfer is taken, and the
// responses coming back are checked in order against those predictions.
module testbench;

    import ils_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    // Op codes 9 to 15 carry no meaning and must be refused as out of range.
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_REVERSE + 4'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    localparam data_t D_MAX  = 32'sh7FFF_FFFF;
    localparam data_t D_MIN  = 32'sh8000_0000;
    localparam data_t D_ONES = -32'sd1;

    localparam int MAX_REPORTS = 10;
    localparam int ITEMS_PER_PHASE = 667;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    req_t  req = '0;
    logic  busy;
    logic  done;
    rsp_t  rsp;

    // One line of the directed part. A row repeated more than once takes fresh
    // random data on every repetition. Where typed is set, the response is the
    // one written into the row; otherwise the shadow list supplies it.
    typedef struct {
        req_t r;
        int   reps;
        bit   typed;
        rsp_t want;
    } step_t;

    step_t directed[$];

    // Shadow of the list held inside the block.
    data_t shadow_cells [CAP];
    int    shadow_len = 0;

    // Responses still owed by the block, oldest first.
    rsp_t  awaited_rsp[$];

    int idle_pct = 0;
    int mismatches = 0;
    int checked = 0;
    int n_done = 0;
    int n_empty = 0;
    int n_full = 0;
    int n_range = 0;
    int n_at_cap = 0;
    bit grow = 1'b1;

    indexed_list_store dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop, well beyond the slowest correct run: every request a reverse
    // of a short list plus the longest idle gap of the sender, over all of the
    // stimulus.
    initial
    begin
        #10_000_000;
        $display("FAIL indexed_list_store");
        $finish;
    end

    function automatic req_t mk_req(logic [OP_W-1:0] op, int pos, data_t d);
        req_t r;
        r.op = op;
        r.position = pos[POS_W-1:0];
        r.data_in = d;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(logic [STATUS_W-1:0] st, data_t rd, int cnt,
                                    data_t first, data_t last);
        rsp_t o;
        o.status = st;
        o.read_data = rd;
        o.count = cnt[COUNT_W-1:0];
        o.first_data = first;
        o.last_data = last;
        return o;
    endfunction

    // Applies one request to the shadow list and returns the response the
    // block owes for it. Refused requests leave the shadow untouched; a full
    // list is refused for insert before the position is looked at.
    function automatic rsp_t predict_list_rsp(req_t r);
        rsp_t  o;
        int    p;
        int    k;
        data_t t;
        bit    full;
        o = '0;
        o.status = ST_DONE;
        p = r.position;
        full = shadow_len >= CAP;
        case (r.op)
            OP_APPEND:
                if (full)
                    o.status = ST_FULL;
                else
                begin
                    shadow_cells[shadow_len] = r.data_in;
                    shadow_len++;
                end
            OP_PREPEND:
                if (full)
                    o.status = ST_FULL;
                else
                begin
                    for (k = shadow_len; k > 0; k--)
                        shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[0] = r.data_in;
                    shadow_len++;
                end
            OP_DEL_LAST:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else
                    shadow_len--;
            OP_DEL_FIRST:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    for (k = 0; k + 1 < shadow_len; k++)
                        shadow_cells[k] = shadow_cells[k+1];
                    shadow_len--;
                end
            OP_READ:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else if (p >= shadow_len)
                    o.status = ST_RANGE;
                else
                    o.read_data = shadow_cells[p];
            OP_WRITE:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else if (p >= shadow_len)
                    o.status = ST_RANGE;
                else
                    shadow_cells[p] = r.data_in;
            OP_INSERT:
                if (full)
                    o.status = ST_FULL;
                else if (p > shadow_len)
                    o.status = ST_RANGE;
                else
                begin
                    for (k = shadow_len; k > p; k--)
                        shadow_cells[k] = shadow_cells[k-1];
                    shadow_cells[p] = r.data_in;
                    shadow_len++;
                end
            OP_DEL_AT:
                if (shadow_len == 0)
                    o.status = ST_EMPTY;
                else if (p >= shadow_len)
                    o.status = ST_RANGE;
                else
                begin
                    for (k = p; k + 1 < shadow_len; k++)
                        shadow_cells[k] = shadow_cells[k+1];
                    shadow_len--;
                end
            OP_REVERSE:
                for (k = 0; k < shadow_len / 2; k++)
                begin
                    t = shadow_cells[k];
                    shadow_cells[k] = shadow_cells[shadow_len-1-k];
                    shadow_cells[shadow_len-1-k] = t;
                end
            default:
                o.status = ST_RANGE;
        endcase
        o.count = shadow_len[COUNT_W-1:0];
        if (shadow_len != 0)
        begin
            o.first_data = shadow_cells[0];
            o.last_data = shadow_cells[shadow_len-1];
        end
        return o;
    endfunction

    // Offers one request, after a random idle gap when the current phase asks
    // for one, and holds it until the block takes the transfer. Inputs are
    // only ever changed at a rising edge and by nonblocking assignment, and
    // start gets a single assignment per edge.
    task automatic send_request(req_t r, bit typed, rsp_t want);
        int   gap;
        rsp_t pred;
        gap = 0;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < 30)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pred = predict_list_rsp(r);
        awaited_rsp.push_back(typed ? want : pred);
    endtask

    // The sender stands back until the block has answered everything.
    task automatic drain_responses();
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_rsp.size() != 0);
    endtask

    function automatic data_t pick_data();
        case ($urandom_range(9))
            0: return D_MAX;
            1: return D_MIN;
            2: return '0;
            3: return D_ONES;
            default: return $urandom;
        endcase
    endfunction

    // Random requests are mostly valid for the current length, so that the
    // list swings between empty and full many times; the tide decides whether
    // entries are mostly being added or removed. A small share is noise: bad
    // positions and the unused op codes.
    function automatic req_t pick_request();
        logic [OP_W-1:0] op;
        int roll;
        int pos;
        if (shadow_len == CAP && $urandom_range(7) == 0)
            grow = 1'b0;
        else if (shadow_len == 0 && $urandom_range(3) == 0)
            grow = 1'b1;
        else if ($urandom_range(99) == 0)
            grow = !grow;
        roll = $urandom_range(99);
        if (roll < 3)
            op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        else if (roll < 9)
            op = OP_REVERSE;
        else if (roll < 21)
            op = OP_READ;
        else if (roll < 29)
            op = OP_WRITE;
        else if (($urandom_range(3) != 0) == grow)
        begin
            case ($urandom_range(2))
                0: op = OP_APPEND;
                1: op = OP_PREPEND;
                default: op = OP_INSERT;
            endcase
        end
        else
        begin
            case ($urandom_range(2))
                0: op = OP_DEL_LAST;
                1: op = OP_DEL_FIRST;
                default: op = OP_DEL_AT;
            endcase
        end
        if ($urandom_range(99) < 85 && shadow_len < CAP)
            pos = $urandom_range(shadow_len, 0);
        else
            pos = $urandom_range(CAP - 1);
        return mk_req(op, pos, pick_data());
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on response %0d, %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     checked, name, $signed(want), want, $signed(got), got);
    endtask

    // Response side: done marks a response for exactly one cycle, and it is
    // sampled at the edge that closes that cycle, before the block updates.
    always @(posedge clk)
    begin
        rsp_t w;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (done !== 1'b1)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("done is unknown at %0t", $realtime);
            end
            else if (awaited_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("response with nothing outstanding at %0t", $realtime);
            end
            else
            begin
                w = awaited_rsp.pop_front();
                checked++;
                if (rsp.status !== w.status)
                    report_field("status", 32'(w.status), 32'(rsp.status));
                if (rsp.read_data !== w.read_data)
                    report_field("read_data", w.read_data, rsp.read_data);
                if (rsp.count !== w.count)
                    report_field("count", 32'(w.count), 32'(rsp.count));
                if (rsp.first_data !== w.first_data)
                    report_field("first_data", w.first_data, rsp.first_data);
                if (rsp.last_data !== w.last_data)
                    report_field("last_data", w.last_data, rsp.last_data);
                case (w.status)
                    ST_DONE:  n_done++;
                    ST_EMPTY: n_empty++;
                    ST_FULL:  n_full++;
                    default:  n_range++;
                endcase
                if (w.count == CAP)
                    n_at_cap++;
            end
        end
    end

    initial
    begin
        step_t s;
        req_t  r;
        int    n;
        int    ph;

        // Every refusal on the empty list, then the extreme values taken in
        // at both ends, reads at and past the tail, insert at the tail and at
        // the head, reverse of one and of many entries, delete at the tail.
        directed.push_back('{mk_req(OP_DEL_LAST, 0, 0), 1, 1,
                             mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_DEL_FIRST, 0, 0), 1, 1,
                             mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_READ, 0, 0), 1, 1,
                             mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_WRITE, 15, D_MAX), 1, 1,
                             mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_DEL_AT, 0, 0), 1, 1,
                             mk_rsp(ST_EMPTY, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_REVERSE, 0, 0), 1, 1,
                             mk_rsp(ST_DONE, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_INSERT, 1, D_ONES), 1, 1,
                             mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_SPARE_LO, 0, 0), 1, 1,
                             mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_SPARE_HI, 15, D_ONES), 1, 1,
                             mk_rsp(ST_RANGE, 0, 0, 0, 0)});
        directed.push_back('{mk_req(OP_APPEND, 0, D_MAX), 1, 1,
                             mk_rsp(ST_DONE, 0, 1, D_MAX, D_MAX)});
        directed.push_back('{mk_req(OP_REVERSE, 0, 0), 1, 1,
                             mk_rsp(ST_DONE, 0, 1, D_MAX, D_MAX)});
        directed.push_back('{mk_req(OP_PREPEND, 0, D_MIN), 1, 1,
                             mk_rsp(ST_DONE, 0, 2, D_MIN, D_MAX)});
        directed.push_back('{mk_req(OP_READ, 1, 0), 1, 1,
                             mk_rsp(ST_DONE, D_MAX, 2, D_MIN, D_MAX)});
        directed.push_back('{mk_req(OP_READ, 2, 0), 1, 1,
                             mk_rsp(ST_RANGE, 0, 2, D_MIN, D_MAX)});
        directed.push_back('{mk_req(OP_INSERT, 2, D_ONES), 1, 1,
                             mk_rsp(ST_DONE, 0, 3, D_MIN, D_ONES)});
        directed.push_back('{mk_req(OP_INSERT, 0, 0), 1, 1,
                             mk_rsp(ST_DONE, 0, 4, 0, D_ONES)});
        directed.push_back('{mk_req(OP_WRITE, 4, D_MAX), 1, 1,
                             mk_rsp(ST_RANGE, 0, 4, 0, D_ONES)});
        directed.push_back('{mk_req(OP_REVERSE, 0, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_DEL_AT, 3, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_DEL_AT, 3, 0), 1, 1,
                             mk_rsp(ST_RANGE, 0, 3, D_ONES, D_MIN)});
        directed.push_back('{mk_req(OP_WRITE, 1, 32'sh5A5A_A5A5), 1, 0, '0});
        // Fill to capacity, then every refusal of a full list; insert is
        // refused as full even with a position that is valid for its length.
        directed.push_back('{mk_req(OP_APPEND, 0, 0), CAP - 3, 0, '0});
        directed.push_back('{mk_req(OP_APPEND, 0, D_ONES), 1, 0, '0});
        directed.push_back('{mk_req(OP_PREPEND, 0, D_ONES), 1, 0, '0});
        directed.push_back('{mk_req(OP_INSERT, 15, D_ONES), 1, 0, '0});
        directed.push_back('{mk_req(OP_REVERSE, 0, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_DEL_FIRST, 0, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_DEL_LAST, 0, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_REVERSE, 0, 0), 1, 0, '0});
        directed.push_back('{mk_req(OP_READ, 13, 0), 1, 0, '0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 6;
        foreach (directed[i])
        begin
            s = directed[i];
            for (n = 0; n < s.reps; n++)
            begin
                r = s.r;
                if (s.reps > 1)
                    r.data_in = $urandom;
                send_request(r, s.typed, s.want);
            end
        end
        drain_responses();

        // Random part in three phases: light sender idling, heavy sender
        // idling, then back-to-back requests. Halfway through the first
        // phase the sender waits for every outstanding response.
        for (ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 6 : (ph == 1) ? 52 : 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_request(pick_request(), 1'b0, '0);
                if (ph == 0 && n == ITEMS_PER_PHASE / 2)
                    drain_responses();
            end
        end
        start <= 1'b0;

        // Wait for the tail of the responses, then a little longer to catch
        // any stray done after a slow reverse.
        n = 0;
        while (awaited_rsp.size() != 0 && n < 1000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (CAP + 4) @(posedge clk);
        if (awaited_rsp.size() != 0)
        begin
            $display("%0d responses never arrived", awaited_rsp.size());
            mismatches += awaited_rsp.size();
        end

        $display("Checked %0d responses: %0d done, %0d empty, %0d full, %0d out of range;",
                 checked, n_done, n_empty, n_full, n_range);
        $display("the list stood at capacity after %0d of them; %0d mismatches in all.",
                 n_at_cap, mismatches);
        if (mismatches == 0)
            $display("PASS indexed_list_store");
        else
            $display("FAIL indexed_list_store");
        $finish;
    end

endmodule
